// ===== rtl/core/cosine_similarity_engine_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cosine similarity engine
// Clocked on i_clk and masked while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef COSINE_SIMILARITY_ENGINE_MACROS_SVH
`define COSINE_SIMILARITY_ENGINE_MACROS_SVH

// cons must hold in the same cycle as ante
`define CSE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define CSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// cse_pkg
// Widths, types and helpers shared by the cosine similarity engine.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam int DOT_W         = 42;   // signed dot product accumulator
    localparam int SQ_W          = 41;   // unsigned squared-norm accumulators
    localparam int SIM_W         = 16;   // Q1.14 result
    localparam int ONE_Q14       = 16384;
    localparam int ROOT_IN_W     = 31;   // bits kept of each norm before the root
    localparam int PROD_W        = 2 * ROOT_IN_W;
    localparam int RES_W         = PROD_W + 1;
    localparam int SHIFT_W       = 4;
    localparam int DEN_W         = 42;
    localparam int NUM_W         = 58;
    localparam int FRAC_SHIFT    = 15;
    localparam int QUOT_W        = 16;
    localparam int QUEUE_DEPTH   = 2;
    localparam int DEF_MAX_LEN   = 1024;
    localparam int DEF_ELEM_BITS = 16;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [SQ_W-1:0]         sq_a;
        logic [SQ_W-1:0]         sq_b;
    } t_sums;

    typedef struct packed {
        logic  valid;
        t_sums sums;
    } t_push;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_NORM,
        ST_MUL,
        ST_SQRT,
        ST_DEN,
        ST_DIVSET,
        ST_CHK,
        ST_DIV,
        ST_DONE
    } t_back_state;

    // Saturation bound of every accumulator: MAX_LEN full-scale pairs, capped.
    function automatic logic [SQ_W-1:0] acc_limit(input int max_len, input int elem_bits);
        int          sh;
        logic [63:0] cap;
        logic [63:0] v;
        sh  = 2 * elem_bits - 2;
        cap = (64'd1 << SQ_W) - 64'd1;
        if (sh >= SQ_W) begin
            v = cap;
        end else begin
            v = 64'(max_len) << sh;
            if (v > cap) begin
                v = cap;
            end
        end
        return v[SQ_W-1:0];
    endfunction

endpackage

// ===== rtl/core/cse_front.sv =====
// ----------------------------------------------------------------------------
// cse_front
// Multiplies each element pair and accumulates the saturating dot product
// and squared norms; hands the finished sums to the queue on the last pair.
// ----------------------------------------------------------------------------
module cse_front #(
    parameter int MAX_LEN   = cse_pkg::DEF_MAX_LEN,
    parameter int ELEM_BITS = cse_pkg::DEF_ELEM_BITS
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_valid,
    input  logic signed [ELEM_BITS-1:0]                  i_elem_a,
    input  logic signed [ELEM_BITS-1:0]                  i_elem_b,
    input  logic                                         i_last,
    input  logic [$clog2(cse_pkg::QUEUE_DEPTH+1)-1:0]    i_queue_count,
    output logic                                         o_ready,
    output cse_pkg::t_push                               o_push
);
    import cse_pkg::*;

    localparam int PW = 2 * ELEM_BITS;
    localparam int SW = ((PW > DOT_W) ? PW : DOT_W) + 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [SQ_W-1:0]      LIMIT   = acc_limit(MAX_LEN, ELEM_BITS);
    localparam logic signed [SW-1:0] POS_LIM = SW'(LIMIT);
    localparam logic signed [SW-1:0] NEG_LIM = -POS_LIM;
    localparam logic [SW-1:0]        SQ_LIM  = SW'(LIMIT);

    logic                   accept;
    logic signed [PW-1:0]   mul_ab;
    logic signed [PW-1:0]   mul_aa;
    logic signed [PW-1:0]   mul_bb;
    logic [CW:0]            pending;

    logic                   r_s1_valid;
    logic                   r_s1_last;
    logic signed [PW-1:0]   r_p_ab;
    logic [PW-1:0]          r_p_aa;
    logic [PW-1:0]          r_p_bb;

    logic signed [DOT_W-1:0] r_dot;
    logic [SQ_W-1:0]         r_sq_a;
    logic [SQ_W-1:0]         r_sq_b;

    logic signed [SW-1:0]    dot_x;
    logic [SW-1:0]           sqa_x;
    logic [SW-1:0]           sqb_x;
    logic signed [DOT_W-1:0] n_dot;
    logic [SQ_W-1:0]         n_sq_a;
    logic [SQ_W-1:0]         n_sq_b;

    // Hold off while the queue could not take the sums of a last pair in flight
    assign pending = {1'b0, i_queue_count} + {{CW{1'b0}}, o_push.valid};
    assign o_ready = pending < (CW+1)'(QUEUE_DEPTH);
    assign accept  = i_valid & o_ready;

    assign mul_ab = i_elem_a * i_elem_b;
    assign mul_aa = i_elem_a * i_elem_a;
    assign mul_bb = i_elem_b * i_elem_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last <= i_last;
        r_p_ab    <= mul_ab;
        r_p_aa    <= mul_aa;
        r_p_bb    <= mul_bb;
    end

    always_comb begin
        dot_x = SW'(r_dot) + SW'(r_p_ab);
        sqa_x = SW'(r_sq_a) + SW'(r_p_aa);
        sqb_x = SW'(r_sq_b) + SW'(r_p_bb);
        if (dot_x > POS_LIM) begin
            n_dot = DOT_W'(POS_LIM);
        end else if (dot_x < NEG_LIM) begin
            n_dot = DOT_W'(NEG_LIM);
        end else begin
            n_dot = DOT_W'(dot_x);
        end
        n_sq_a = (sqa_x > SQ_LIM) ? LIMIT : SQ_W'(sqa_x);
        n_sq_b = (sqb_x > SQ_LIM) ? LIMIT : SQ_W'(sqb_x);
    end

    assign o_push.valid     = r_s1_valid & r_s1_last;
    assign o_push.sums.dot  = n_dot;
    assign o_push.sums.sq_a = n_sq_a;
    assign o_push.sums.sq_b = n_sq_b;

    // Clear the sums once a vector's totals leave for the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dot  <= '0;
            r_sq_a <= '0;
            r_sq_b <= '0;
        end else if (r_s1_valid) begin
            if (r_s1_last) begin
                r_dot  <= '0;
                r_sq_a <= '0;
                r_sq_b <= '0;
            end else begin
                r_dot  <= n_dot;
                r_sq_a <= n_sq_a;
                r_sq_b <= n_sq_b;
            end
        end
    end

endmodule

// ===== rtl/core/cse_queue.sv =====
// ----------------------------------------------------------------------------
// cse_queue
// Short queue of finished vector sums between front and back.
// ----------------------------------------------------------------------------
`include "cosine_similarity_engine_macros.svh"

module cse_queue (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  cse_pkg::t_push                            i_push,
    input  logic                                      i_pop,
    output logic                                      o_valid,
    output cse_pkg::t_sums                            o_head,
    output logic [$clog2(cse_pkg::QUEUE_DEPTH+1)-1:0] o_count
);
    import cse_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_sums           r_mem [QUEUE_DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            r_count <= r_count + CW'(i_push.valid) - CW'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.sums;
        end
    end

    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    `CSE_ASSERT_IMP(a_no_overflow, i_push.valid, r_count < CW'(QUEUE_DEPTH), "queue overflow")
    `CSE_ASSERT_IMP(a_no_underflow, i_pop, r_count != '0, "pop from empty queue")
    `CSE_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CW'(QUEUE_DEPTH), "queue count beyond depth")

endmodule

// ===== rtl/core/cse_back.sv =====
// ----------------------------------------------------------------------------
// cse_back
// Sequencer that turns one vector's sums into a Q1.14 similarity: normalise,
// multiply, bit-pair square root, then restoring divide with rounding.
// ----------------------------------------------------------------------------
`include "cosine_similarity_engine_macros.svh"

module cse_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  cse_pkg::t_sums                    i_head,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic signed [cse_pkg::SIM_W-1:0]  o_similarity,
    output logic                              o_zero_norm
);
    import cse_pkg::*;

    localparam int CNT_W = $clog2(QUOT_W);

    t_back_state             r_state;
    t_back_state             n_state;

    logic signed [DOT_W-1:0] r_dot,  n_dot;
    logic [SQ_W-1:0]         r_sa,   n_sa;
    logic [SQ_W-1:0]         r_sb,   n_sb;
    logic [SHIFT_W-1:0]      r_ka,   n_ka;
    logic [SHIFT_W-1:0]      r_kb,   n_kb;
    logic [PROD_W-1:0]       r_rem,  n_rem;
    logic [RES_W-1:0]        r_res,  n_res;
    logic [RES_W-1:0]        r_bit,  n_bit;
    logic [DEN_W-1:0]        r_d,    n_d;
    logic [NUM_W-1:0]        r_num,  n_num;
    logic [NUM_W-1:0]        r_den,  n_den;
    logic                    r_ovf,  n_ovf;
    logic [QUOT_W-1:0]       r_q,    n_q;
    logic [CNT_W-1:0]        r_cnt,  n_cnt;
    logic                    r_zero, n_zero;

    logic                    r_out_valid, n_out_valid;
    logic [SIM_W-1:0]        r_out_sim,   n_out_sim;
    logic                    r_out_zero,  n_out_zero;

    logic                    a_big;
    logic                    b_big;
    logic                    head_zero;
    logic [PROD_W-1:0]       root_prod;
    logic [RES_W:0]          trial;
    logic [SHIFT_W:0]        k_sum;
    logic [ROOT_IN_W-1:0]    root;
    logic [DOT_W-1:0]        mag;
    logic [SIM_W-1:0]        q_sat;

    assign a_big     = |r_sa[SQ_W-1:ROOT_IN_W];
    assign b_big     = |r_sb[SQ_W-1:ROOT_IN_W];
    assign head_zero = (i_head.sq_a == '0) || (i_head.sq_b == '0);
    assign root_prod = r_sa[ROOT_IN_W-1:0] * r_sb[ROOT_IN_W-1:0];
    assign trial     = {1'b0, r_res} + {1'b0, r_bit};
    assign k_sum     = {1'b0, r_ka} + {1'b0, r_kb};
    assign root      = (r_res[ROOT_IN_W-1:0] == '0) ? ROOT_IN_W'(1) : r_res[ROOT_IN_W-1:0];
    assign mag       = r_dot[DOT_W-1] ? DOT_W'(-r_dot) : DOT_W'(r_dot);
    assign q_sat     = (r_ovf || (r_q > QUOT_W'(ONE_Q14))) ? SIM_W'(ONE_Q14) : SIM_W'(r_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dot      <= n_dot;
        r_sa       <= n_sa;
        r_sb       <= n_sb;
        r_ka       <= n_ka;
        r_kb       <= n_kb;
        r_rem      <= n_rem;
        r_res      <= n_res;
        r_bit      <= n_bit;
        r_d        <= n_d;
        r_num      <= n_num;
        r_den      <= n_den;
        r_ovf      <= n_ovf;
        r_q        <= n_q;
        r_cnt      <= n_cnt;
        r_zero     <= n_zero;
        r_out_sim  <= n_out_sim;
        r_out_zero <= n_out_zero;
    end

    always_comb begin
        n_state     = r_state;
        n_dot       = r_dot;
        n_sa        = r_sa;
        n_sb        = r_sb;
        n_ka        = r_ka;
        n_kb        = r_kb;
        n_rem       = r_rem;
        n_res       = r_res;
        n_bit       = r_bit;
        n_d         = r_d;
        n_num       = r_num;
        n_den       = r_den;
        n_ovf       = r_ovf;
        n_q         = r_q;
        n_cnt       = r_cnt;
        n_zero      = r_zero;
        n_out_valid = r_out_valid & ~i_ready;
        n_out_sim   = r_out_sim;
        n_out_zero  = r_out_zero;
        o_pop       = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_pop   = 1'b1;
                    n_dot   = i_head.dot;
                    n_sa    = i_head.sq_a;
                    n_sb    = i_head.sq_b;
                    n_ka    = '0;
                    n_kb    = '0;
                    n_zero  = head_zero;
                    n_state = head_zero ? ST_DONE : ST_NORM;
                end
            end
            ST_NORM: begin
                // Shift each norm down until it fits, one bit a cycle
                if (a_big || b_big) begin
                    if (a_big) begin
                        n_sa = r_sa >> 1;
                        n_ka = r_ka + 1'b1;
                    end
                    if (b_big) begin
                        n_sb = r_sb >> 1;
                        n_kb = r_kb + 1'b1;
                    end
                end else begin
                    // Even out the total shift so the root takes half of it
                    if (r_ka[0] ^ r_kb[0]) begin
                        if (r_ka >= r_kb) begin
                            n_sa = r_sa >> 1;
                            n_ka = r_ka + 1'b1;
                        end else begin
                            n_sb = r_sb >> 1;
                            n_kb = r_kb + 1'b1;
                        end
                    end
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_rem   = root_prod;
                n_res   = '0;
                n_bit   = {1'b1, {PROD_W{1'b0}}};
                n_state = ST_SQRT;
            end
            ST_SQRT: begin
                if ({2'b00, r_rem} >= trial) begin
                    n_rem = r_rem - trial[PROD_W-1:0];
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                if (r_bit[0]) begin
                    n_state = ST_DEN;
                end
            end
            ST_DEN: begin
                n_d     = DEN_W'(root) << k_sum[SHIFT_W:1];
                n_state = ST_DIVSET;
            end
            ST_DIVSET: begin
                n_num   = (NUM_W'(mag) << FRAC_SHIFT) + NUM_W'(r_d);
                n_den   = NUM_W'(r_d) << (FRAC_SHIFT + 1);
                n_state = ST_CHK;
            end
            ST_CHK: begin
                // A quotient beyond the divide's reach saturates anyway
                n_ovf   = r_num >= (r_den << 1);
                n_q     = '0;
                n_cnt   = CNT_W'(QUOT_W - 1);
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_num >= r_den) begin
                    n_num = r_num - r_den;
                    n_q   = {r_q[QUOT_W-2:0], 1'b1};
                end else begin
                    n_q   = {r_q[QUOT_W-2:0], 1'b0};
                end
                n_den = r_den >> 1;
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_zero  = r_zero;
                    if (r_zero) begin
                        n_out_sim = '0;
                    end else if (r_dot[DOT_W-1]) begin
                        n_out_sim = -q_sat;
                    end else begin
                        n_out_sim = q_sat;
                    end
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_valid      = r_out_valid;
    assign o_similarity = r_out_sim;
    assign o_zero_norm  = r_out_zero;

    `CSE_ASSERT_IMP(a_zero_gives_zero, o_valid && o_zero_norm, o_similarity == '0, "zero norm with nonzero similarity")
    `CSE_ASSERT_IMP(a_sim_range, o_valid, (o_similarity <= SIM_W'(ONE_Q14)) && (o_similarity >= -SIM_W'(ONE_Q14)), "similarity outside plus or minus one")
    `CSE_ASSERT_NEXT(a_pop_starts_work, o_pop, r_state != ST_IDLE, "popped sums not taken up")

endmodule

// ===== rtl/core/cosine_similarity_engine.sv =====
// ----------------------------------------------------------------------------
// cosine_similarity_engine
// Streaming cosine similarity of two Q3.12 vectors, result in Q1.14.
// ----------------------------------------------------------------------------
// Element pairs enter one per cycle while s_tready is high, with tlast on
// the final pair; the front multiplies and accumulates saturating sums with
// no stalls of its own. Each vector's sums then go through a two-entry queue
// to a sequencer that loads them, normalises both norms, multiplies, takes
// 32 square-root steps, runs the ST_DEN, ST_DIVSET and ST_CHK setup states
// and takes 16 divide steps before the hand-off to the output register; when
// either norm is zero it goes from the load straight to the hand-off. Vectors
// whose pairs outlast a sequencer pass stream at one pair per cycle; shorter
// ones are paced by the sequencer once the queue fills, and the input stalls
// on s_tready until an entry frees.
// ----------------------------------------------------------------------------
module cosine_similarity_engine #(
    parameter int MAX_LEN   = cse_pkg::DEF_MAX_LEN,
    parameter int ELEM_BITS = cse_pkg::DEF_ELEM_BITS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((2*ELEM_BITS+7)/8)*8-1:0]      s_tdata,   // elem_a, elem_b
    input  logic                                  s_tlast,   // last pair of the vectors
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [cse_pkg::SIM_W-1:0]             m_tdata,   // similarity
    output logic [0:0]                            m_tuser    // zero_norm
);
    import cse_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_push                   push;
    t_sums                   head;
    logic                    head_valid;
    logic                    pop;
    logic [CW-1:0]           queue_count;
    logic signed [SIM_W-1:0] similarity;
    logic                    zero_norm;

    cse_front #(
        .MAX_LEN   (MAX_LEN),
        .ELEM_BITS (ELEM_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_tvalid),
        .i_elem_a      ($signed(s_tdata[ELEM_BITS-1:0])),
        .i_elem_b      ($signed(s_tdata[2*ELEM_BITS-1:ELEM_BITS])),
        .i_last        (s_tlast),
        .i_queue_count (queue_count),
        .o_ready       (s_tready),
        .o_push        (push)
    );

    cse_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_head  (head),
        .o_count (queue_count)
    );

    cse_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (m_tvalid),
        .i_ready      (m_tready),
        .o_similarity (similarity),
        .o_zero_norm  (zero_norm)
    );

    assign m_tdata    = similarity;
    assign m_tuser[0] = zero_norm;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Streams element-pair vectors into the cosine similarity engine and checks
// every Q1.14 result and zero-norm flag against a cycle-free predictor that
// keeps its own saturating sums. Covers single pairs, zero norms, full-scale
// extremes, long full-scale vectors and random vectors with and without random stalls.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_LEN   = 1024;
    localparam int ELEM_BITS = 16;
    localparam int SAT_SHIFT = 2 * ELEM_BITS - 2;
    localparam longint unsigned SUM_CAP   = (64'd1 << 41) - 64'd1;
    localparam longint unsigned SUM_LIMIT =
        (SAT_SHIFT >= 41) ? SUM_CAP :
        (((64'(MAX_LEN) << SAT_SHIFT) > SUM_CAP) ? SUM_CAP : (64'(MAX_LEN) << SAT_SHIFT));
    localparam int LATENCY_WAIT = 80;
    localparam int LONG_LEN     = 64;

    typedef enum int {
        MIX_FULL,
        MIX_SMALL,
        MIX_EXTREME,
        MIX_MATCHED,
        MIX_ZERO_A,
        MIX_ZERO_B
    } t_elem_mix;

    typedef struct {
        logic signed [15:0] similarity;
        logic               zero_norm;
    } t_cos_result;

    logic        i_clk    = 1'b0;
    logic        i_rst_n  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;    // elem_a, elem_b
    logic        s_tlast  = 1'b0;  // last pair of the vectors
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // similarity
    logic [0:0]  m_tuser;          // zero_norm

    // predictor copy of the running sums
    logic signed [41:0] dot_sum_q   = '0;
    logic [40:0]        norm_a_sum  = '0;
    logic [40:0]        norm_b_sum  = '0;

    t_cos_result expected_results[$];
    int          fail_count    = 0;
    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;

    cosine_similarity_engine #(
        .MAX_LEN   (MAX_LEN),
        .ELEM_BITS (ELEM_BITS)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int bit_len(longint unsigned v);
        int n;
        n = 0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int i = 31; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // dot / sqrt(na * nb) in Q1.14, rounded half away from zero, clamped to +-1
    function automatic logic signed [15:0] cosine_q14(longint dot, longint unsigned na,
                                                      longint unsigned nb);
        int              sh_a;
        int              sh_b;
        longint unsigned root;
        longint unsigned den;
        longint unsigned mag;
        longint unsigned quo;
        sh_a = (bit_len(na) > 31) ? bit_len(na) - 31 : 0;
        sh_b = (bit_len(nb) > 31) ? bit_len(nb) - 31 : 0;
        // keep the total shift even so the root can take half of it
        if ((sh_a + sh_b) % 2 != 0) begin
            if (sh_a >= sh_b) begin
                sh_a++;
            end else begin
                sh_b++;
            end
        end
        root = int_sqrt((na >> sh_a) * (nb >> sh_b));
        if (root == 0) begin
            root = 1;
        end
        den = root << ((sh_a + sh_b) / 2);
        mag = (dot < 0) ? longint'(-dot) : longint'(dot);
        quo = ((mag << 15) + den) / (2 * den);
        if (quo > 16384) begin
            quo = 16384;
        end
        return (dot < 0) ? -16'(quo) : 16'(quo);
    endfunction

    function automatic void accumulate_pair(logic [15:0] a, logic [15:0] b, logic last);
        longint          sa;
        longint          sb;
        longint          dsum;
        longint unsigned nsum;
        t_cos_result     res;
        sa   = longint'($signed(a));
        sb   = longint'($signed(b));
        dsum = longint'(dot_sum_q) + sa * sb;
        if (dsum > longint'(SUM_LIMIT)) begin
            dsum = longint'(SUM_LIMIT);
        end else if (dsum < -longint'(SUM_LIMIT)) begin
            dsum = -longint'(SUM_LIMIT);
        end
        dot_sum_q = dsum[41:0];
        nsum = 64'(norm_a_sum) + longint'(sa * sa);
        norm_a_sum = (nsum > SUM_LIMIT) ? SUM_LIMIT[40:0] : nsum[40:0];
        nsum = 64'(norm_b_sum) + longint'(sb * sb);
        norm_b_sum = (nsum > SUM_LIMIT) ? SUM_LIMIT[40:0] : nsum[40:0];
        if (last) begin
            if (norm_a_sum == 0 || norm_b_sum == 0) begin
                res.similarity = '0;
                res.zero_norm  = 1'b1;
            end else begin
                res.similarity = cosine_q14(longint'(dot_sum_q), 64'(norm_a_sum),
                                            64'(norm_b_sum));
                res.zero_norm  = 1'b0;
            end
            expected_results.push_back(res);
            dot_sum_q  = '0;
            norm_a_sum = '0;
            norm_b_sum = '0;
        end
    endfunction

    function automatic logic [15:0] extreme_elem();
        case ($urandom_range(4))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'h0001;
            default: return 16'hffff;
        endcase
    endfunction

    // Hold tvalid low on idle cycles, then present the word until taken.
    task automatic send_pair(input logic [15:0] a, input logic [15:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {b, a};
        s_tlast  <= last;
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        accumulate_pair(a, b, last);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result word: similarity %0d zero_norm %0b",
                       $signed(m_tdata), m_tuser[0]);
                fail_count++;
            end else begin
                if (m_tdata !== expected_results[0].similarity) begin
                    $error("similarity: expected %0d, actual %0d",
                           expected_results[0].similarity, $signed(m_tdata));
                    fail_count++;
                end
                if (m_tuser[0] !== expected_results[0].zero_norm) begin
                    $error("zero_norm: expected %0b, actual %0b",
                           expected_results[0].zero_norm, m_tuser[0]);
                    fail_count++;
                end
                void'(expected_results.pop_front());
            end
        end
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    task automatic test_zero_norm();
        send_pair(16'h0000, 16'h0000, 1'b1);
        send_pair(16'h0000, 16'h0005, 1'b1);
        send_pair(16'hfff9, 16'h0000, 1'b1);
        send_pair(16'h0000, 16'h0003, 1'b0);
        send_pair(16'h0000, 16'h8000, 1'b0);
        send_pair(16'h0000, 16'h0001, 1'b1);
    endtask

    task automatic test_extremes();
        send_pair(16'h8000, 16'h8000, 1'b1);
        send_pair(16'h7fff, 16'h8000, 1'b1);
        send_pair(16'h8000, 16'h7fff, 1'b1);
        send_pair(16'h0001, 16'h0001, 1'b1);
        send_pair(16'h0001, 16'hffff, 1'b1);
        send_pair(16'h7fff, 16'h7fff, 1'b1);
        // orthogonal pair of vectors
        send_pair(16'h0001, 16'h0000, 1'b0);
        send_pair(16'h0000, 16'h0001, 1'b1);
        send_pair(16'h7fff, 16'hffff, 1'b0);
        send_pair(16'h8000, 16'h0001, 1'b0);
        send_pair(16'h0001, 16'h7fff, 1'b1);
    endtask

    // Long full-scale vectors push both norms well past 31 bits.
    task automatic test_long_vectors();
        for (int i = 0; i < LONG_LEN; i++) begin
            send_pair(16'h8000, 16'h8000, i == LONG_LEN - 1);
        end
        for (int i = 0; i < LONG_LEN; i++) begin
            send_pair(16'h8000, ($urandom_range(7) == 0) ? 16'h8000 : 16'h7fff,
                      i == LONG_LEN - 1);
        end
    endtask

    task automatic test_random_vectors(input int n_items);
        int          sent;
        int          len;
        int          pick;
        t_elem_mix   mix;
        logic [15:0] a;
        logic [15:0] b;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            len  = (pick < 70) ? $urandom_range(6, 1) :
                   (pick < 95) ? $urandom_range(24, 7) : $urandom_range(60, 25);
            if (len > n_items - sent) begin
                len = n_items - sent;
            end
            pick = $urandom_range(99);
            mix  = (pick < 40) ? MIX_FULL :
                   (pick < 60) ? MIX_SMALL :
                   (pick < 75) ? MIX_EXTREME :
                   (pick < 90) ? MIX_MATCHED :
                   (pick < 95) ? MIX_ZERO_A : MIX_ZERO_B;
            for (int i = 0; i < len; i++) begin
                a = 16'($urandom);
                b = 16'($urandom);
                case (mix)
                    MIX_SMALL: begin
                        a = 16'($signed($urandom_range(16)) - 8);
                        b = 16'($signed($urandom_range(16)) - 8);
                    end
                    MIX_EXTREME: begin
                        a = extreme_elem();
                        b = extreme_elem();
                    end
                    MIX_MATCHED: begin
                        // near-parallel vectors push the quotient against the clamp
                        b = $urandom_range(1) ? a : -a;
                        b = b + 16'($urandom_range(6)) - 16'd3;
                    end
                    MIX_ZERO_A: a = '0;
                    MIX_ZERO_B: b = '0;
                    default: ;
                endcase
                send_pair(a, b, i == len - 1);
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 29;
        sink_idle_pct = 70;
        test_zero_norm();
        test_extremes();
        test_long_vectors();
        test_random_vectors(170);
        // hold the stream until every result is back
        wait_drained();

        src_idle_pct  = 70;
        sink_idle_pct = 29;
        test_random_vectors(170);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_random_vectors(165);

        wait_drained();
        repeat (LATENCY_WAIT) @(posedge i_clk);
        if (expected_results.size() != 0) begin
            $error("%0d results never arrived", expected_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/cse_pkg.sv
rtl/core/cse_front.sv
rtl/core/cse_queue.sv
rtl/core/cse_back.sv
rtl/core/cosine_similarity_engine.sv
tb/sv/tb_top.sv
